@@ sv/tt_pkg.sv @@
// Transposition table package: item, result and slot entry types, bound and kind codes.
// No dependencies; transposition_table_unit imports it.
package tt_pkg;

    localparam logic KIND_STORE = 1'b0;
    localparam logic KIND_PROBE = 1'b1;

    localparam logic [1:0] BOUND_EXACT = 2'd0;
    localparam logic [1:0] BOUND_LOWER = 2'd1;
    localparam logic [1:0] BOUND_UPPER = 2'd2;

    typedef struct packed {
        logic               kind;
        logic [63:0]        pos_hash;
        logic signed [31:0] score;
        logic [5:0]         search_depth;
        logic [1:0]         bound_type;
        logic [4:0]         move_x;
        logic [4:0]         move_y;
        logic signed [31:0] window_alpha;
        logic signed [31:0] window_beta;
    } item_t;

    typedef struct packed {
        logic               was_probe;
        logic               written;
        logic               matched;
        logic               usable;
        logic signed [31:0] found_score;
        logic [4:0]         found_x;
        logic [4:0]         found_y;
    } result_t;

    // one slot of the table; move_x in the upper half of mv
    typedef struct packed {
        logic [63:0]        tag;
        logic signed [31:0] score;
        logic [5:0]         depth;
        logic [1:0]         bound;
        logic [9:0]         mv;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

@@ sv/tt_stream_if.sv @@
// Valid/ready stream interface, payload type set by the instantiating level.
// Used for the item and result channels of the transposition table; no dependencies.
interface tt_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (
        output valid,
        output data,
        input  ready
    );

    modport sink (
        input  valid,
        input  data,
        output ready
    );
endinterface

@@ sv/tt_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; used for the slot storage of the transposition table.
module tt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

@@ sv/transposition_table_unit.sv @@
// Transposition table top level: direct-mapped slot store with depth-preferred replacement.
// Depends on tt_pkg, tt_stream_if and tt_ram.
//
// Usage:
//   req  (sink)   : one store or probe item per handshake (valid and ready high at clk).
//   rsp  (source) : exactly one result per item, in item order.
//   Each item is handled in two steps: the slot is read from the RAM in the cycle the item
//   is taken, and the next cycle compares it, writes the slot back and produces the
//   result. Since the RAM read is registered, req.ready is low while an item is pending,
//   so a new item is taken only once the last one has been compared.
//   Results go into a two-deep output buffer, so a new item is taken while one
//   result waits; when both places are full req.ready drops until rsp drains.
//   After reset the table is swept clear, one slot per cycle, and req.ready stays
//   low until every slot has been cleared.
//   A probe with hash zero never matches, since tag zero marks an empty slot.
module transposition_table_unit #(
    parameter int TABLE_ENTRIES = 4096
) (
    input  logic      clk,
    input  logic      rst_n,
    tt_stream_if.sink   req,
    tt_stream_if.source rsp
);
    import tt_pkg::*;

    localparam int AW = $clog2(TABLE_ENTRIES);

    logic          clearing_reg;
    logic [AW-1:0] clr_addr_reg;
    logic          pend_reg;
    item_t         item_reg;
    logic          out_valid_reg;
    result_t       out_reg;
    logic          skid_valid_reg;
    result_t       skid_reg;

    logic          accept;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    entry_t        ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    entry_t        slot;
    entry_t        new_entry;
    logic          do_write;
    logic          hit;
    logic          cut;
    result_t       res;
    logic          pop;

    assign req.ready = !clearing_reg && !pend_reg && !skid_valid_reg;
    assign accept    = req.valid && req.ready;
    assign pop       = out_valid_reg && rsp.ready;

    tt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (req.data.pos_hash[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign slot = entry_t'(ram_rdata);

    always_comb
    begin
        new_entry.tag   = item_reg.pos_hash;
        new_entry.score = item_reg.score;
        new_entry.depth = item_reg.search_depth;
        new_entry.bound = item_reg.bound_type;
        new_entry.mv    = {item_reg.move_x, item_reg.move_y};

        do_write = (slot.tag == 64'd0) || (slot.depth <= item_reg.search_depth);
        hit      = (item_reg.pos_hash != 64'd0) && (slot.tag == item_reg.pos_hash)
                   && (slot.depth >= item_reg.search_depth);

        case (slot.bound)
            BOUND_EXACT: cut = 1'b1;
            BOUND_LOWER: cut = slot.score >= item_reg.window_beta;
            BOUND_UPPER: cut = item_reg.window_alpha >= slot.score;
            default:     cut = 1'b0;
        endcase

        res = '0;
        if (item_reg.kind == KIND_STORE)
        begin
            res.written = do_write;
        end
        else
        begin
            res.was_probe = 1'b1;
            if (hit)
            begin
                res.matched     = 1'b1;
                res.usable      = cut;
                res.found_score = slot.score;
                res.found_x     = slot.mv[9:5];
                res.found_y     = slot.mv[4:0];
            end
        end

        if (clearing_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = pend_reg && (item_reg.kind == KIND_STORE) && do_write;
            ram_waddr = item_reg.pos_hash[AW-1:0];
            ram_wdata = new_entry;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg   <= 1'b1;
            clr_addr_reg   <= '0;
            pend_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (clearing_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == AW'(TABLE_ENTRIES - 1))
                begin
                    clearing_reg <= 1'b0;
                end
            end
            pend_reg <= accept;

            // skid is empty whenever a result is pushed: only one item in flight
            if (pend_reg)
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    skid_valid_reg <= 1'b1;
                end
            end
            else if (pop)
            begin
                out_valid_reg  <= skid_valid_reg;
                skid_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= req.data;
        end
        if (pend_reg)
        begin
            if (!out_valid_reg || rsp.ready)
            begin
                out_reg <= res;
            end
            else
            begin
                skid_reg <= res;
            end
        end
        else if (pop)
        begin
            out_reg <= skid_reg;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;
endmodule
